// ----- src/i2c_master_byte_engine_core_defines.svh -----
// Assertion macros shared by the I2C master byte engine.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checked from reset itself, so reset does not disable it.
`define MBE_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/i2c_mbe_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
// Used by the front, back and top-level modules; depends on nothing.
package i2c_mbe_pkg;

    localparam int unsigned CfgWidth = 16;
    localparam int unsigned CfgIdxWidth = 2;

    localparam logic [CfgIdxWidth-1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_ACK_TIMEOUT = 2'd1;

    localparam logic [CfgWidth-1:0] HALF_PERIOD_RST = 16'd100;
    localparam logic [CfgWidth-1:0] ACK_TIMEOUT_RST = 16'd1000;

    localparam logic [2:0] CODE_NONE  = 3'd0;
    localparam logic [2:0] CODE_START = 3'd1;
    localparam logic [2:0] CODE_STOP  = 3'd2;
    localparam logic [2:0] CODE_WRITE = 3'd3;
    localparam logic [2:0] CODE_READ  = 3'd4;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] write_byte;
        logic       send_nack;
        logic       sda_sample;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_link;

endpackage

// ----- src/i2c_mbe_front.sv -----
// Front part: accepts input items, decodes the command code and holds
// them in a two-entry queue for the back part. Depends on i2c_mbe_pkg.
module i2c_mbe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          i_cmd,
    input  logic [7:0]          i_write_byte,
    input  logic                i_send_nack,
    input  logic                i_sda_sample,
    output i2c_mbe_pkg::t_link  o_link,
    input  logic                i_take
);

    i2c_mbe_pkg::t_item r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    i2c_mbe_pkg::t_item w_item;
    logic               w_push_ok;
    logic               w_pop_ok;

    always_comb begin
        w_item.write_byte = i_write_byte;
        w_item.send_nack  = i_send_nack;
        w_item.sda_sample = i_sda_sample;
        case (i_cmd)
            i2c_mbe_pkg::CODE_START: w_item.cmd = i2c_mbe_pkg::CMD_START;
            i2c_mbe_pkg::CODE_STOP:  w_item.cmd = i2c_mbe_pkg::CMD_STOP;
            i2c_mbe_pkg::CODE_WRITE: w_item.cmd = i2c_mbe_pkg::CMD_WRITE;
            i2c_mbe_pkg::CODE_READ:  w_item.cmd = i2c_mbe_pkg::CMD_READ;
            default:                 w_item.cmd = i2c_mbe_pkg::CMD_NONE;
        endcase
    end

    assign full         = (r_cnt == 2'd2);
    assign w_push_ok    = push && !full;
    assign w_pop_ok     = i_take && (r_cnt != 2'd0);
    assign o_link.valid = (r_cnt != 2'd0);
    assign o_link.item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wp <= ~r_wp;
            end
            if (w_pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push_ok} - {1'b0, w_pop_ok};
        end
    end

endmodule

// ----- src/i2c_mbe_back.sv -----
// Back part: the pin sequencer, one step per item, and a two-entry result
// queue toward the output. Holds the configuration. Depends on i2c_mbe_pkg.
module i2c_mbe_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [i2c_mbe_pkg::CfgIdxWidth-1:0] i_cfg_idx,
    input  logic [i2c_mbe_pkg::CfgWidth-1:0]    i_cfg_data,
    input  i2c_mbe_pkg::t_link                  i_link,
    output logic                                o_take,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_scl_level,
    output logic                                o_sda_level,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic [7:0]                          o_read_byte,
    output logic                                o_ack_missing
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B,
        PH_WR_LO, PH_WR_HI, PH_WA_LO, PH_WA_HI,
        PH_RD_LO, PH_RD_HI, PH_RA_LO, PH_RA_HI
    } t_phase;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] read_byte;
        logic       ack_missing;
    } t_res;

    logic [15:0] r_half_period, r_ack_timeout;
    t_phase      r_phase, n_phase;
    logic [15:0] r_delay, n_delay;
    logic [3:0]  r_bits, n_bits;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_wait, n_wait;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_nack, n_nack;
    logic [7:0]  r_last_read, n_last_read;
    logic        r_ack_fail, n_ack_fail;
    logic        n_done;

    t_res        r_out [2];
    logic        r_owp, r_orp;
    logic [1:0]  r_ocnt;
    t_res        w_res;
    logic        w_pop_ok;
    logic [15:0] w_hold, w_limit, w_wait_inc;
    logic [3:0]  w_bits_inc;
    logic [7:0]  w_shift_wr, w_shift_rd;
    i2c_mbe_pkg::t_item w_it;

    assign w_it       = i_link.item;
    assign o_take     = i_link.valid && (r_ocnt != 2'd2);
    assign w_pop_ok   = pop && (r_ocnt != 2'd0);
    assign w_hold     = (r_half_period == 16'd0) ? 16'd1 : r_half_period;
    assign w_limit    = (r_ack_timeout == 16'd0) ? 16'd1 : r_ack_timeout;
    assign w_wait_inc = r_wait + 16'd1;
    assign w_bits_inc = r_bits + 4'd1;
    assign w_shift_wr = {r_shift[6:0], 1'b0};
    assign w_shift_rd = {r_shift[6:0], w_it.sda_sample};

    always_comb begin
        n_phase     = r_phase;
        n_delay     = r_delay;
        n_bits      = r_bits;
        n_shift     = r_shift;
        n_wait      = r_wait;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_nack      = r_nack;
        n_last_read = r_last_read;
        n_ack_fail  = r_ack_fail;
        n_done      = 1'b0;
        if (r_phase == PH_IDLE) begin
            case (w_it.cmd)
                i2c_mbe_pkg::CMD_START: begin
                    n_phase = PH_ST_A; n_delay = w_hold; n_scl = 1'b1; n_sda = 1'b1;
                end
                i2c_mbe_pkg::CMD_STOP: begin
                    n_phase = PH_SP_A; n_delay = w_hold; n_scl = 1'b1; n_sda = 1'b0;
                end
                i2c_mbe_pkg::CMD_WRITE: begin
                    n_shift    = w_it.write_byte;
                    n_bits     = 4'd0;
                    n_ack_fail = 1'b0;
                    n_phase    = PH_WR_LO;
                    n_delay    = w_hold;
                    n_scl      = 1'b0;
                    n_sda      = w_it.write_byte[7];
                end
                i2c_mbe_pkg::CMD_READ: begin
                    n_nack  = w_it.send_nack;
                    n_shift = 8'd0;
                    n_bits  = 4'd0;
                    n_phase = PH_RD_LO; n_delay = w_hold; n_scl = 1'b0; n_sda = 1'b1;
                end
                default: ;
            endcase
        end else if (r_phase == PH_WA_HI) begin
            if (!w_it.sda_sample) begin
                n_ack_fail = 1'b0;
                n_scl      = 1'b0;
                n_phase    = PH_IDLE;
                n_delay    = 16'd0;
                n_done     = 1'b1;
            end else begin
                n_wait = w_wait_inc;
                if ((w_wait_inc >= w_limit) || (w_wait_inc == 16'd0)) begin
                    n_ack_fail = 1'b1;
                    n_scl      = 1'b0;
                    n_phase    = PH_IDLE;
                    n_delay    = 16'd0;
                    n_done     = 1'b1;
                end
            end
        end else if (r_delay > 16'd1) begin
            n_delay = r_delay - 16'd1;
        end else begin
            case (r_phase)
                PH_ST_A: begin
                    n_phase = PH_ST_B; n_delay = w_hold; n_scl = 1'b1; n_sda = 1'b0;
                end
                PH_SP_A: begin
                    n_phase = PH_SP_B; n_delay = w_hold; n_scl = 1'b1; n_sda = 1'b1;
                end
                PH_ST_B, PH_SP_B: begin
                    n_phase = PH_IDLE; n_delay = 16'd0; n_done = 1'b1;
                end
                PH_WR_LO: begin
                    n_phase = PH_WR_HI; n_delay = w_hold; n_scl = 1'b1;
                end
                PH_WR_HI: begin
                    n_shift = w_shift_wr;
                    n_bits  = w_bits_inc;
                    n_delay = w_hold;
                    n_scl   = 1'b0;
                    if (w_bits_inc >= 4'd8) begin
                        n_phase = PH_WA_LO; n_sda = 1'b1;
                    end else begin
                        n_phase = PH_WR_LO; n_sda = w_shift_wr[7];
                    end
                end
                PH_WA_LO: begin
                    n_wait = 16'd0; n_phase = PH_WA_HI; n_delay = 16'd0;
                    n_scl = 1'b1; n_sda = 1'b1;
                end
                PH_RD_LO: begin
                    n_phase = PH_RD_HI; n_delay = w_hold; n_scl = 1'b1; n_sda = 1'b1;
                end
                PH_RD_HI: begin
                    n_shift = w_shift_rd;
                    n_bits  = w_bits_inc;
                    n_delay = w_hold;
                    n_scl   = 1'b0;
                    if (w_bits_inc >= 4'd8) begin
                        n_phase = PH_RA_LO; n_sda = r_nack;
                    end else begin
                        n_phase = PH_RD_LO; n_sda = 1'b1;
                    end
                end
                PH_RA_LO: begin
                    n_phase = PH_RA_HI; n_delay = w_hold; n_scl = 1'b1;
                end
                PH_RA_HI: begin
                    n_scl       = 1'b0;
                    n_last_read = r_shift;
                    n_phase     = PH_IDLE;
                    n_delay     = 16'd0;
                    n_done      = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE; n_delay = 16'd0;
                end
            endcase
        end
    end

    always_comb begin
        w_res.scl         = n_scl;
        w_res.sda         = n_sda;
        w_res.busy        = (n_phase != PH_IDLE);
        w_res.done        = n_done;
        w_res.read_byte   = n_last_read;
        w_res.ack_missing = n_ack_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2c_mbe_pkg::HALF_PERIOD_RST;
            r_ack_timeout <= i2c_mbe_pkg::ACK_TIMEOUT_RST;
            r_phase       <= PH_IDLE;
            r_delay       <= 16'd0;
            r_bits        <= 4'd0;
            r_shift       <= 8'd0;
            r_wait        <= 16'd0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_nack        <= 1'b0;
            r_last_read   <= 8'd0;
            r_ack_fail    <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == i2c_mbe_pkg::REG_HALF_PERIOD)) begin
                r_half_period <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == i2c_mbe_pkg::REG_ACK_TIMEOUT)) begin
                r_ack_timeout <= i_cfg_data;
            end
            if (o_take) begin
                r_phase     <= n_phase;
                r_delay     <= n_delay;
                r_bits      <= n_bits;
                r_shift     <= n_shift;
                r_wait      <= n_wait;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_nack      <= n_nack;
                r_last_read <= n_last_read;
                r_ack_fail  <= n_ack_fail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out[r_owp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (o_take) begin
                r_owp <= ~r_owp;
            end
            if (w_pop_ok) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, o_take} - {1'b0, w_pop_ok};
        end
    end

    assign empty         = (r_ocnt == 2'd0);
    assign o_scl_level   = r_out[r_orp].scl;
    assign o_sda_level   = r_out[r_orp].sda;
    assign o_busy_res    = r_out[r_orp].busy;
    assign o_done_res    = r_out[r_orp].done;
    assign o_read_byte   = r_out[r_orp].read_byte;
    assign o_ack_missing = r_out[r_orp].ack_missing;

endmodule

// ----- src/i2c_master_byte_engine_core.sv -----
// Top level of the I2C master byte engine: front decoder and queue, back
// sequencer and result queue. Depends on i2c_mbe_pkg, i2c_mbe_front, i2c_mbe_back.
//
//  Channel   Handshake        Payload
//  input     push / full      i_cmd, i_write_byte, i_send_nack, i_sda_sample
//  result    empty / pop      o_scl_level, o_sda_level, o_busy_res, o_done_res,
//                             o_read_byte, o_ack_missing
//  config    i_cfg_we         i_cfg_idx, i_cfg_data
//
// One item a cycle sustained while results are popped; each item gives one result
// item. An item passes from push to the result ports through the front queue,
// then one step of the sequencer into the result queue. Each side has a two-entry
// queue, so a stalled pop backs up into full only after four items. Reset is
// synchronous and active low and leaves both queues empty.
`include "i2c_master_byte_engine_core_defines.svh"

module i2c_master_byte_engine_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [2:0]                          i_cmd,
    input  logic [7:0]                          i_write_byte,
    input  logic                                i_send_nack,
    input  logic                                i_sda_sample,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_scl_level,
    output logic                                o_sda_level,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic [7:0]                          o_read_byte,
    output logic                                o_ack_missing,
    input  logic                                i_cfg_we,
    input  logic [i2c_mbe_pkg::CfgIdxWidth-1:0] i_cfg_idx,
    input  logic [i2c_mbe_pkg::CfgWidth-1:0]    i_cfg_data
);

    i2c_mbe_pkg::t_link w_link;
    logic               w_take;

    i2c_mbe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_write_byte (i_write_byte),
        .i_send_nack  (i_send_nack),
        .i_sda_sample (i_sda_sample),
        .o_link       (w_link),
        .i_take       (w_take)
    );

    i2c_mbe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_link        (w_link),
        .o_take        (w_take),
        .empty         (empty),
        .pop           (pop),
        .o_scl_level   (o_scl_level),
        .o_sda_level   (o_sda_level),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_read_byte   (o_read_byte),
        .o_ack_missing (o_ack_missing)
    );

    `MBE_ASSERT_RESET(a_reset_empty, empty && !full, "Queues not empty after reset.")
    `MBE_ASSERT_NEXT(a_push_reaches_back, push && !full, w_link.valid,
        "Accepted item did not reach the sequencer.")
    `MBE_ASSERT_SAME(a_full_has_item, full, w_link.valid, "Front queue full but no item.")
    `MBE_ASSERT_SAME(a_done_not_busy, !empty && o_done_res, !o_busy_res,
        "Done result still reports busy.")

endmodule
